>>> hw/rtl/windowed_event_rate_meter_top_defines.svh
// assertion macros for the windowed event rate meter
// expects clk and rst in the scope of each use
`ifndef WINDOWED_EVENT_RATE_METER_TOP_DEFINES_SVH
`define WINDOWED_EVENT_RATE_METER_TOP_DEFINES_SVH

`ifndef SYNTH
`define WERM_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define WERM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define WERM_ASSERT_IMP(name, pre, post, msg)
`define WERM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

>>> hw/rtl/werm_pkg.sv
// shared constants and types of the windowed event rate meter
// no dependencies
package werm_pkg;

  localparam int STAMP_W = 32;
  localparam int RATE_W = 18;
  localparam int COUNT_W = 7;
  localparam int HZ_W = 10;
  localparam int RATE_HZ = 1000;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_SOURCE_COUNT = 2;
  localparam int DEF_FRAC_BITS = 8;

  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/werm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on werm_pkg
module werm_div #(
  parameter int DVD_W = werm_pkg::STAMP_W,
  parameter int DVS_W = werm_pkg::STAMP_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output werm_pkg::div_stat_t stat,
  output logic [DVD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      dvs_q <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_LOAD;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_LAST);
      if (cnt != '0) begin
        cnt <= cnt - CNT_LAST;
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> hw/rtl/windowed_event_rate_meter_top.sv
// windowed event rate meter, top level: sequencer, window store, stats walk
// depends on werm_pkg, werm_div, windowed_event_rate_meter_top_defines.svh
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   [31:0] stamp_ms                         [0] source
//   m_axis   out  [17:0] event_rate [35:18] average_rate  [0] source_out
//                 [53:36] peak_rate [60:54] sample_count  [1] accepted
//
// an event's time is set by the shared divider (rate, then average) over DVD_W bits,
// DVD_W being the wider of 10+FRAC_BITS and 18+log2(WINDOW_DEPTH), and by the
// one-read-per-cycle peak walk over the fill; a full window also passes the evict state
// a duplicate stamp skips the rate divide, a source out of range goes straight to done
// reset clears per-source stamps, fill, head and sum; the sample store is not cleared
// no beat is taken while a result waits; a result waits for a busy output register
`include "windowed_event_rate_meter_top_defines.svh"

module windowed_event_rate_meter_top #(
  parameter int WINDOW_DEPTH = werm_pkg::DEF_WINDOW_DEPTH,
  parameter int SOURCE_COUNT = werm_pkg::DEF_SOURCE_COUNT,
  parameter int FRAC_BITS    = werm_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [werm_pkg::STAMP_W-1:0]      s_axis_tdata,   // stamp_ms
  input  logic [0:0]                        s_axis_tuser,   // source
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [werm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // event_rate, average_rate,
                                                            // peak_rate, sample_count
  output logic [werm_pkg::OUT_USER_W-1:0]   m_axis_tuser    // source_out, accepted
);

  import werm_pkg::*;

  localparam int IDX_W      = $clog2(WINDOW_DEPTH);
  localparam int POS_W      = IDX_W + 1;
  localparam int FILL_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int SRC_W      = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int SUM_W      = RATE_W + IDX_W;
  localparam int RATE_NUM_W = HZ_W + FRAC_BITS;
  localparam int DVD_W      = (RATE_NUM_W > SUM_W) ? RATE_NUM_W : SUM_W;
  localparam int PAD_W      = OUT_DATA_W - 3 * RATE_W - COUNT_W;

  localparam logic [RATE_NUM_W-1:0] RATE_NUM   = RATE_NUM_W'(RATE_HZ) << FRAC_BITS;
  localparam logic [POS_W-1:0]      DEPTH_POS  = POS_W'(WINDOW_DEPTH);
  localparam logic [FILL_W-1:0]     DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHECK    = 10'b00_0000_0010,
    S_RATE_DIV = 10'b00_0000_0100,
    S_PUSH     = 10'b00_0000_1000,
    S_EVICT    = 10'b00_0001_0000,
    S_COMMIT   = 10'b00_0010_0000,
    S_STATS    = 10'b00_0100_0000,
    S_AVG_DIV  = 10'b00_1000_0000,
    S_WALK     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_pos(input logic [POS_W-1:0] i);
    logic [POS_W-1:0] d;
    d = (i >= DEPTH_POS) ? i - DEPTH_POS : i;
    return d[IDX_W-1:0];
  endfunction

  state_t state, state_next;

  logic                src_q;
  logic [STAMP_W-1:0]  stamp_q;
  logic [SRC_W-1:0]    src_idx;
  logic                src_ok;
  logic                dup;

  logic [STAMP_W-1:0]  last_stamp [SOURCE_COUNT];
  logic                stamp_seen [SOURCE_COUNT];
  logic [FILL_W-1:0]   win_fill   [SOURCE_COUNT];
  logic [IDX_W-1:0]    win_head   [SOURCE_COUNT];
  logic [SUM_W-1:0]    win_sum    [SOURCE_COUNT];

  logic [RATE_W-1:0]   win_mem [SOURCE_COUNT][WINDOW_DEPTH];
  logic [RATE_W-1:0]   win_rd;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wpos;
  logic [IDX_W-1:0]    mem_rpos;
  logic [IDX_W-1:0]    add_pos;
  logic [IDX_W-1:0]    walk_pos;

  logic [FILL_W-1:0]   cur_fill;
  logic [IDX_W-1:0]    cur_head;
  logic [SUM_W-1:0]    cur_sum;
  logic [RATE_W-1:0]   cur_rate;
  logic [RATE_W-1:0]   cur_avg;
  logic [RATE_W-1:0]   cur_peak;
  logic                cur_acc;
  logic                full;
  logic [FILL_W-1:0]   walk_k;
  logic                cmp_valid;

  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [STAMP_W-1:0]  div_dvs;
  logic [DVD_W-1:0]    div_quo;
  div_stat_t           div_stat;
  logic [RATE_W-1:0]   rate_sat;

  logic                out_free;
  logic                out_src;
  logic                out_acc;
  logic [RATE_W-1:0]   out_rate;
  logic [RATE_W-1:0]   out_avg;
  logic [RATE_W-1:0]   out_peak;
  logic [COUNT_W-1:0]  out_count;

  assign src_idx = SRC_W'(src_q);
  assign src_ok  = (int'(src_q) < SOURCE_COUNT);
  assign dup     = stamp_seen[src_idx] && (stamp_q == last_stamp[src_idx]);
  assign full    = !(cur_fill < DEPTH_FILL);
  assign add_pos  = wrap_pos({1'b0, cur_head} + POS_W'(cur_fill[IDX_W-1:0]));
  assign walk_pos = wrap_pos({1'b0, cur_head} + POS_W'(walk_k[IDX_W-1:0]));
  assign rate_sat = (div_quo > DVD_W'(RATE_MAX)) ? RATE_MAX : div_quo[RATE_W-1:0];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  // shared divider: rate in check, average in stats
  assign div_start = ((state == S_CHECK) && src_ok && !dup && stamp_seen[src_idx])
                  || ((state == S_STATS) && (cur_fill != '0));
  assign div_dvd = (state == S_STATS) ? DVD_W'(cur_sum) : DVD_W'(RATE_NUM);
  assign div_dvs = (state == S_STATS) ? STAMP_W'(cur_fill) : stamp_q - last_stamp[src_idx];

  werm_div #(
    .DVD_W (DVD_W),
    .DVS_W (STAMP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (!src_ok) state_next = S_DONE;
        else if (dup) state_next = S_STATS;
        else if (!stamp_seen[src_idx]) state_next = S_PUSH;
        else state_next = S_RATE_DIV;
      end
      S_RATE_DIV: begin
        if (div_stat.done) state_next = S_PUSH;
      end
      S_PUSH: begin
        state_next = full ? S_EVICT : S_COMMIT;
      end
      S_EVICT: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_STATS;
      end
      S_STATS: begin
        state_next = (cur_fill == '0) ? S_DONE : S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (div_stat.done) state_next = S_WALK;
      end
      S_WALK: begin
        if (walk_k == cur_fill) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sample store
  assign mem_we   = ((state == S_PUSH) && !full) || (state == S_EVICT);
  assign mem_wpos = (state == S_EVICT) ? cur_head : add_pos;
  assign mem_rpos = (state == S_WALK) ? walk_pos : cur_head;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[src_idx][mem_wpos] <= cur_rate;
    end
    win_rd <= win_mem[src_idx][mem_rpos];
  end

  // control and per-source state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      cmp_valid     <= 1'b0;
      for (int s = 0; s < SOURCE_COUNT; s++) begin
        last_stamp[s] <= '0;
        stamp_seen[s] <= 1'b0;
        win_fill[s]   <= '0;
        win_head[s]   <= '0;
        win_sum[s]    <= '0;
      end
    end else begin
      state     <= state_next;
      cmp_valid <= (state == S_WALK) && (walk_k != cur_fill);
      if ((state == S_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == S_COMMIT) begin
        last_stamp[src_idx] <= stamp_q;
        stamp_seen[src_idx] <= 1'b1;
        win_fill[src_idx]   <= cur_fill;
        win_head[src_idx]   <= cur_head;
        win_sum[src_idx]    <= cur_sum;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        src_q   <= s_axis_tuser[0];
        stamp_q <= s_axis_tdata;
      end
      S_CHECK: begin
        cur_head <= win_head[src_idx];
        cur_sum  <= win_sum[src_idx];
        cur_rate <= '0;
        cur_avg  <= '0;
        cur_acc  <= src_ok && !dup;
        cur_fill <= src_ok ? win_fill[src_idx] : '0;
      end
      S_RATE_DIV: begin
        if (div_stat.done) cur_rate <= rate_sat;
      end
      S_PUSH: begin
        if (!full) begin
          cur_fill <= cur_fill + FILL_W'(1);
          cur_sum  <= cur_sum + SUM_W'(cur_rate);
        end
      end
      S_EVICT: begin
        cur_sum  <= cur_sum - SUM_W'(win_rd) + SUM_W'(cur_rate);
        cur_head <= wrap_pos({1'b0, cur_head} + POS_W'(1));
      end
      S_STATS: begin
        walk_k <= '0;
      end
      S_AVG_DIV: begin
        if (div_stat.done) cur_avg <= div_quo[RATE_W-1:0];
      end
      S_WALK: begin
        if (walk_k != cur_fill) walk_k <= walk_k + FILL_W'(1);
      end
      S_COMMIT, S_DONE: begin
      end
      default: begin
      end
    endcase

    if ((state == S_CHECK) || (state == S_STATS)) begin
      cur_peak <= '0;
    end else if (cmp_valid && (win_rd > cur_peak)) begin
      cur_peak <= win_rd;
    end

    if ((state == S_DONE) && out_free) begin
      out_src   <= src_q;
      out_acc   <= cur_acc;
      out_rate  <= cur_rate;
      out_avg   <= cur_avg;
      out_peak  <= cur_peak;
      out_count <= COUNT_W'(cur_fill);
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_count, out_peak, out_avg, out_rate};
  assign m_axis_tuser = {out_acc, out_src};

  `WERM_ASSERT_IMP(a_peak_ge_avg, m_axis_tvalid, out_peak >= out_avg, "peak below average")
  `WERM_ASSERT_IMP(a_ignored_no_rate, m_axis_tvalid && !out_acc, out_rate == '0, "ignored rate")
  `WERM_ASSERT_IMP(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  `WERM_ASSERT_NEXT(a_one_event, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy beat")
  `WERM_ASSERT_IMP(a_fill_bound, 1'b1, win_fill[0] <= DEPTH_FILL, "window fill beyond depth")

endmodule
